/* src/onc_pkg.sv */
package onc_pkg;

   // Port field width and result mask geometry
   localparam int PORT_W      = 3;
   localparam int MASK_W      = 4;
   localparam int MASK_STAGES = 3;

   // Default network depth: 8 ports
   localparam int DEF_STAGES = 3;

   // Switch fault flag bits
   localparam int FLAG_BCAST_BIT  = 0;
   localparam int FLAG_REDUCE_BIT = 1;
   localparam int FLAG_W          = 2;

   typedef logic [FLAG_W-1:0] flag_type;
   typedef logic [MASK_W-1:0] mask_type;

endpackage

/* src/omega_network_conflict_check.sv */
// Omega network routing conflict checker.
// Request channel (req_*): one source/destination route per transaction.
//   req_start_req = 1 wipes every switch claim and fault flag before the
//   route is applied, so it marks the first route of a new permutation.
// Response channel (rsp_*): one transaction per request, in order, with
//   the per-stage switch fault masks, a "new fault" flag and a pass flag.
// A request is taken into the input register, resolved, and its response
//   is held in the result register while rsp_valid is high.
// Throughput: one route per cycle while responses are taken. All STAGES switch
//   stages are resolved in flat logic on the claim/fault registers, so the next
//   route sees the state left by the previous one without a bubble.
// Stall: if rsp_ready is low while a response is held, the input register
//   still fills; once both are occupied req_ready drops until the response
//   is taken. Nothing is dropped or repeated.
// Reset: synchronous, active high. Clears both pipeline valid bits, all
//   switch claims and all fault flags; no clearing pass is needed.
// STAGES sets the network size (2^STAGES ports). Only switches 0..3 of the
//   first three stages appear in the mask fields; all count toward pass.
module omega_network_conflict_check #(
   parameter int STAGES = onc_pkg::DEF_STAGES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_start_req,
   input  logic [onc_pkg::PORT_W-1:0] req_source_port,
   input  logic [onc_pkg::PORT_W-1:0] req_dest_port,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_route_conflict,
   output logic                       rsp_network_pass,
   output logic [onc_pkg::MASK_W-1:0] rsp_faults_stage_a,
   output logic [onc_pkg::MASK_W-1:0] rsp_faults_stage_b,
   output logic [onc_pkg::MASK_W-1:0] rsp_faults_stage_c
);
   import onc_pkg::*;

   localparam int HALF = 2 ** (STAGES - 1);
   localparam int SW_W = STAGES - 1;
   // port values are zero-extended when the network is wider than the field
   localparam int EXT_W = (STAGES > PORT_W) ? STAGES : PORT_W;

   // ---------------------------------------------------------------
   // Handshake: two-entry pipe (input register, result register)
   // ---------------------------------------------------------------
   logic in_valid_ff;
   logic out_valid_ff;
   logic advance;
   logic fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;

   // input register
   logic               start_ff;
   logic [PORT_W-1:0]  src_ff;
   logic [PORT_W-1:0]  dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         start_ff <= req_start_req;
         src_ff   <= req_source_port;
         dst_ff   <= req_dest_port;
      end
   end

   // ---------------------------------------------------------------
   // Switch state: per input a claim valid bit and direction, per
   // switch a broadcast and a reduction fault flag.
   // ---------------------------------------------------------------
   logic [STAGES-1:0][HALF-1:0][1:0] claim_valid_ff, claim_valid_in;
   logic [STAGES-1:0][HALF-1:0][1:0] claim_dir_ff,   claim_dir_in;
   logic [STAGES-1:0][HALF-1:0][FLAG_W-1:0] fault_ff, fault_in, fault_base;

   logic [EXT_W-1:0]  src_ext;
   logic [EXT_W-1:0]  dst_ext;
   logic [STAGES-1:0] pos;
   logic [SW_W-1:0]   sw_v;
   logic              inp_v;
   logic              dir_v;

   assign src_ext = EXT_W'(src_ff);
   assign dst_ext = EXT_W'(dst_ff);

   always_comb begin
      // start_req clears everything before this route is applied
      claim_valid_in = start_ff ? '0 : claim_valid_ff;
      claim_dir_in   = start_ff ? '0 : claim_dir_ff;
      fault_base     = start_ff ? '0 : fault_ff;
      fault_in       = fault_base;
      pos            = src_ext[STAGES-1:0];
      sw_v           = '0;
      inp_v          = 1'b0;
      dir_v          = 1'b0;
      for (int k = 0; k < STAGES; k++) begin
         // shuffle: switch = pos mod HALF, input = pos div HALF
         sw_v  = pos[SW_W-1:0];
         inp_v = pos[STAGES-1];
         dir_v = dst_ext[STAGES-1-k];
         if (!claim_valid_in[k][sw_v][inp_v]) begin
            claim_valid_in[k][sw_v][inp_v] = 1'b1;
            claim_dir_in[k][sw_v][inp_v]   = dir_v;
            // reduction: other input already holds this output
            if (claim_valid_in[k][sw_v][!inp_v] &&
                (claim_dir_in[k][sw_v][!inp_v] == dir_v)) begin
               fault_in[k][sw_v][FLAG_REDUCE_BIT] = 1'b1;
            end
         end else if (claim_dir_in[k][sw_v][inp_v] != dir_v) begin
            // broadcast: same input asks for both outputs
            fault_in[k][sw_v][FLAG_BCAST_BIT] = 1'b1;
         end
         pos = {sw_v, dir_v};
      end
   end

   // flags only ever set, so any set bit not in the base is new
   logic raised;
   assign raised = |(fault_in & ~fault_base);

   // per-switch fault summary
   logic [STAGES-1:0][HALF-1:0] sw_fault;
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         for (int i = 0; i < HALF; i++) begin
            sw_fault[k][i] = |fault_in[k][i];
         end
      end
   end

   mask_type [MASK_STAGES-1:0] mask;
   always_comb begin
      mask = '0;
      for (int k = 0; k < MASK_STAGES; k++) begin
         for (int i = 0; i < MASK_W; i++) begin
            if (k < STAGES && i < HALF) begin
               mask[k][i] = sw_fault[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         claim_valid_ff <= '0;
         claim_dir_ff   <= '0;
         fault_ff       <= '0;
      end else if (fire) begin
         claim_valid_ff <= claim_valid_in;
         claim_dir_ff   <= claim_dir_in;
         fault_ff       <= fault_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic     conflict_ff;
   logic     pass_ff;
   mask_type mask_a_ff;
   mask_type mask_b_ff;
   mask_type mask_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         conflict_ff <= raised;
         pass_ff     <= !(|sw_fault);
         mask_a_ff   <= mask[0];
         mask_b_ff   <= mask[1];
         mask_c_ff   <= mask[2];
      end
   end

   assign rsp_route_conflict = conflict_ff;
   assign rsp_network_pass   = pass_ff;
   assign rsp_faults_stage_a = mask_a_ff;
   assign rsp_faults_stage_b = mask_b_ff;
   assign rsp_faults_stage_c = mask_c_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("pipe not empty after reset");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ready)
      else $error("input register overrun");

   a_pass_masks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_network_pass) |->
         (rsp_faults_stage_a == '0 && rsp_faults_stage_b == '0 &&
          rsp_faults_stage_c == '0))
      else $error("pass flag with faults shown");

   a_conflict_fails: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_route_conflict) |-> !rsp_network_pass)
      else $error("new fault but network passes");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(fault_ff))
      else $error("fault flags changed without a route");

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import onc_pkg::*;

   // Network geometry for the default build: 3 stages, 4 switches per stage.
   localparam int NSTAGES = DEF_STAGES;
   localparam int NPORTS  = 1 << NSTAGES;
   localparam int HALF    = NPORTS / 2;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ROUTES = 1850;
   // Watchdog bound, far above the slowest legal run.
   localparam int CYCLE_LIMIT = 200000;
   // Margin for a straggler response.
   localparam int DRAIN_CYCLES = 16;

   // Kinds of random route groups.
   typedef enum int {
      GRP_PERMUTE,
      GRP_PASSABLE,
      GRP_REPEAT,
      GRP_NOISE
   } group_kind_type;

   typedef struct {
      bit            start;
      bit [PORT_W-1:0] src;
      bit [PORT_W-1:0] dst;
      int            gap;     // idle cycles before this transaction is offered
   } route_item_type;

   typedef struct {
      logic     conflict;
      logic     pass;
      mask_type stage_a;
      mask_type stage_b;
      mask_type stage_c;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_start_req = 1'b0;
   logic [PORT_W-1:0]   req_source_port = '0;
   logic [PORT_W-1:0]   req_dest_port = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_route_conflict;
   logic                rsp_network_pass;
   logic [MASK_W-1:0]   rsp_faults_stage_a;
   logic [MASK_W-1:0]   rsp_faults_stage_b;
   logic [MASK_W-1:0]   rsp_faults_stage_c;

   omega_network_conflict_check dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_source_port    (req_source_port),
      .req_dest_port      (req_dest_port),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_route_conflict (rsp_route_conflict),
      .rsp_network_pass   (rsp_network_pass),
      .rsp_faults_stage_a (rsp_faults_stage_a),
      .rsp_faults_stage_b (rsp_faults_stage_b),
      .rsp_faults_stage_c (rsp_faults_stage_c)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the network state: per switch input a claim bit and the
   // claimed direction, per switch the sticky broadcast/reduction flags.
   // ---------------------------------------------------------------------
   bit       claimed   [NSTAGES][HALF][2];
   bit       claim_dir [NSTAGES][HALF][2];
   flag_type sw_fault  [NSTAGES][HALF];

   route_item_type pending_routes[$];
   verdict_type    expected_verdicts[$];
   int          failures = 0;
   int          cycles = 0;
   int          tx_wait = 0;
   int          tx_calm = 0;
   int          rx_stall = 0;
   int          rx_calm = 0;
   int          rx_draw;

   // Walk one route through the shuffle stages, update the shadow state
   // and return the verdict the block must report for it.
   function automatic verdict_type route_through_network(bit start, bit [PORT_W-1:0] src,
                                                         bit [PORT_W-1:0] dst);
      int       pos, sw, inp, k, i;
      bit       dir;
      flag_type prior, now_flags;
      verdict_type v;
      v.conflict = 1'b0;
      v.pass     = 1'b1;
      v.stage_a  = '0;
      v.stage_b  = '0;
      v.stage_c  = '0;
      if (start) begin
         for (k = 0; k < NSTAGES; k++) begin
            for (i = 0; i < HALF; i++) begin
               claimed[k][i]   = '{default: 1'b0};
               claim_dir[k][i] = '{default: 1'b0};
               sw_fault[k][i]  = '0;
            end
         end
      end
      pos = int'(src);
      for (k = 0; k < NSTAGES; k++) begin
         sw  = pos % HALF;
         inp = (pos / HALF) & 1;
         dir = dst[NSTAGES-1-k];   // MSB steers the first stage
         prior     = sw_fault[k][sw];
         now_flags = prior;
         if (!claimed[k][sw][inp]) begin
            claimed[k][sw][inp]   = 1'b1;
            claim_dir[k][sw][inp] = dir;
            // Other input already owns this output: reduction
            if (claimed[k][sw][inp^1] && claim_dir[k][sw][inp^1] == dir)
               now_flags[FLAG_REDUCE_BIT] = 1'b1;
         end else if (claim_dir[k][sw][inp] != dir) begin
            // Same input asked for both outputs: broadcast
            now_flags[FLAG_BCAST_BIT] = 1'b1;
         end
         if (now_flags != prior)
            v.conflict = 1'b1;
         sw_fault[k][sw] = now_flags;
         pos = (sw * 2 + int'(dir)) & (NPORTS - 1);
      end
      for (k = 0; k < NSTAGES; k++) begin
         for (i = 0; i < HALF; i++) begin
            if (sw_fault[k][i] != '0) begin
               v.pass = 1'b0;
               if (i < MASK_W) begin
                  case (k)
                     0: v.stage_a[i] = 1'b1;
                     1: v.stage_b[i] = 1'b1;
                     2: v.stage_c[i] = 1'b1;
                     default: ;
                  endcase
               end
            end
         end
      end
      return v;
   endfunction

   // Queue one route; the sender gap comes in bursts with calm stretches.
   task automatic add_route(bit start, int src, int dst);
      route_item_type it;
      it.start = start;
      it.src   = src[PORT_W-1:0];
      it.dst   = dst[PORT_W-1:0];
      if (tx_calm > 0) begin
         tx_calm--;
         it.gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         tx_calm = $urandom_range(20, 80);
         it.gap  = 0;
      end else begin
         it.gap = $urandom_range(0, 3);
      end
      pending_routes.push_back(it);
   endtask

   task automatic shuffle_ports(ref int a[NPORTS]);
      int j, t, n;
      for (n = 0; n < NPORTS; n++)
         a[n] = n;
      for (n = NPORTS - 1; n > 0; n--) begin
         j    = $urandom_range(0, n);
         t    = a[n];
         a[n] = a[j];
         a[j] = t;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int          perm[NPORTS];
      int          order[NPORTS];
      int          made, n, len, c, s;
      bit          lead;
      group_kind_type kind;

      // Directed part
      add_route(1'b0, 5, 2);          // straight from reset state
      add_route(1'b1, 0, 0);
      add_route(1'b0, 0, 0);          // identical route again: no fault
      add_route(1'b0, 0, 7);          // same input, other direction: broadcast
      add_route(1'b1, 0, 0);
      add_route(1'b0, 4, 1);          // both inputs of switch 0 want output 0
      for (n = 0; n < NPORTS; n++)    // identity permutation routes clean
         add_route(n == 0, n, n);
      add_route(1'b1, 7, 0);
      add_route(1'b0, 0, 7);
      add_route(1'b0, 7, 7);
      add_route(1'b1, 7, 7);
      add_route(1'b0, 3, 3);
      add_route(1'b0, 3, 4);

      // Random part: mostly complete permutations, some passable by
      // construction, plus repeats and unstructured noise.
      made = 0;
      while (made < RANDOM_ROUTES) begin
         kind = group_kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 4)
            kind = GRP_PERMUTE;
         // Occasionally a group does not open with start: broken sequence
         lead = ($urandom_range(0, 5) != 0);
         shuffle_ports(order);
         case (kind)
            GRP_PERMUTE: begin
               shuffle_ports(perm);
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, NPORTS) : NPORTS;
               for (n = 0; n < len; n++)
                  add_route(n == 0 && lead, order[n], perm[order[n]]);
               made += len;
            end
            GRP_PASSABLE: begin
               // Uniform shifts and XOR patterns go through without blocking
               c = $urandom_range(0, NPORTS - 1);
               s = $urandom_range(0, 1);
               for (n = 0; n < NPORTS; n++)
                  add_route(n == 0 && lead, order[n],
                            s ? ((order[n] + c) % NPORTS) : (order[n] ^ c));
               made += NPORTS;
            end
            GRP_REPEAT: begin
               shuffle_ports(perm);
               len = $urandom_range(4, 12);
               for (n = 0; n < len; n++) begin
                  c = $urandom_range(0, NPORTS - 1);
                  add_route(n == 0 && lead, c, perm[c]);
               end
               made += len;
            end
            default: begin
               len = $urandom_range(1, 8);
               for (n = 0; n < len; n++)
                  add_route($urandom_range(0, 7) == 0, $urandom_range(0, NPORTS - 1),
                            $urandom_range(0, NPORTS - 1));
               made += len;
            end
         endcase
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Everything offered and accepted, then every response back.
      while (pending_routes.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: holds a transaction until accepted; predicts the
   // verdict at the accepting edge so the expectation precedes the response.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(
               route_through_network(req_start_req, req_source_port, req_dest_port));
            if (pending_routes.size() != 0 && pending_routes[0].gap == 0) begin
               // back-to-back: valid stays high, payload moves on
               req_start_req   <= pending_routes[0].start;
               req_source_port <= pending_routes[0].src;
               req_dest_port   <= pending_routes[0].dst;
               void'(pending_routes.pop_front());
            end else begin
               req_valid <= 1'b0;
               tx_wait   <= (pending_routes.size() != 0) ? pending_routes[0].gap - 1 : 0;
            end
         end else if (!req_valid) begin
            if (tx_wait > 0) begin
               tx_wait <= tx_wait - 1;
            end else if (pending_routes.size() != 0) begin
               req_valid       <= 1'b1;
               req_start_req   <= pending_routes[0].start;
               req_source_port <= pending_routes[0].src;
               req_dest_port   <= pending_routes[0].dst;
               void'(pending_routes.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compares each accepted transaction with the oldest
   // expectation, then may drop ready for a random stall.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("response with no outstanding route request");
               failures++;
            end else begin
               check_field("route_conflict", 32'(expected_verdicts[0].conflict),
                           32'(rsp_route_conflict));
               check_field("network_pass", 32'(expected_verdicts[0].pass),
                           32'(rsp_network_pass));
               check_field("faults_stage_a", 32'(expected_verdicts[0].stage_a),
                           32'(rsp_faults_stage_a));
               check_field("faults_stage_b", 32'(expected_verdicts[0].stage_b),
                           32'(rsp_faults_stage_b));
               check_field("faults_stage_c", 32'(expected_verdicts[0].stage_c),
                           32'(rsp_faults_stage_c));
               void'(expected_verdicts.pop_front());
            end
            if (rx_calm > 0) begin
               rx_calm--;
               rx_draw = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_calm = $urandom_range(20, 80);
               rx_draw = 0;
            end else begin
               rx_draw = $urandom_range(0, 3);
            end
            if (rx_draw == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               rx_stall  <= rx_draw - 1;
            end
         end else if (!rsp_ready) begin
            if (rx_stall > 0)
               rx_stall <= rx_stall - 1;
            else
               rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
